>>> rtl/core/sbc_pkg.sv
// Package for the swept box collision core: default widths, register
// reset value and result codes. No dependencies.
package sbc_pkg;

    localparam int COORD_WIDTH_DEF   = 32;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int QUEUE_DEPTH       = 2;

    localparam int THR_W = 16;
    localparam logic [THR_W-1:0] THR_RESET = 16'd7;

    localparam int TIME_W = 17;

    localparam logic [1:0] AXIS_X    = 2'd0;
    localparam logic [1:0] AXIS_Y    = 2'd1;
    localparam logic [1:0] AXIS_Z    = 2'd2;
    localparam logic [1:0] AXIS_NONE = 2'd3;

    localparam logic signed [1:0] NORMAL_NONE = 2'sb00;
    localparam logic signed [1:0] NORMAL_POS  = 2'sb01;
    localparam logic signed [1:0] NORMAL_NEG  = 2'sb11;

endpackage

>>> rtl/core/sbc_if.sv
// Channel interfaces of the swept box collision core: item input, result
// output and threshold register write. Depends on sbc_pkg.
interface sbc_in_if #(
    parameter int COORD_WIDTH = sbc_pkg::COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic                          mode;
    logic signed [COORD_WIDTH-1:0] box_low_x;
    logic signed [COORD_WIDTH-1:0] box_low_y;
    logic signed [COORD_WIDTH-1:0] box_low_z;
    logic signed [COORD_WIDTH-1:0] box_high_x;
    logic signed [COORD_WIDTH-1:0] box_high_y;
    logic signed [COORD_WIDTH-1:0] box_high_z;
    logic signed [COORD_WIDTH-1:0] velocity_x;
    logic signed [COORD_WIDTH-1:0] velocity_y;
    logic signed [COORD_WIDTH-1:0] velocity_z;

    modport source (output valid, mode, box_low_x, box_low_y, box_low_z,
                    box_high_x, box_high_y, box_high_z,
                    velocity_x, velocity_y, velocity_z, input ready);
    modport sink (input valid, mode, box_low_x, box_low_y, box_low_z,
                  box_high_x, box_high_y, box_high_z,
                  velocity_x, velocity_y, velocity_z, output ready);
endinterface

interface sbc_out_if;
    logic                            valid;
    logic                            ready;
    logic                            hit;
    logic [sbc_pkg::TIME_W-1:0]      entry_time;
    logic [sbc_pkg::TIME_W-1:0]      exit_time;
    logic [1:0]                      hit_axis;
    logic signed [1:0]               normal_sign;

    modport source (output valid, hit, entry_time, exit_time, hit_axis, normal_sign,
                    input ready);
    modport sink (input valid, hit, entry_time, exit_time, hit_axis, normal_sign,
                  output ready);
endinterface

interface sbc_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [sbc_pkg::THR_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

>>> rtl/core/sbc_fifo.sv
// Short job queue between front and back end of the collision core.
// Depends on sbc_pkg.
module sbc_fifo #(
    parameter type t_item = logic
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_data,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_data
);
    localparam int DEPTH = sbc_pkg::QUEUE_DEPTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    t_item          r_mem [DEPTH];
    logic [AW-1:0]  r_wp, r_rp;
    logic [CW-1:0]  r_cnt;
    logic           do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule

>>> rtl/core/sbc_front.sv
// Front end: takes items, keeps the mover and threshold, classifies each
// obstacle test into divider jobs. Depends on sbc_pkg and sbc_if.
module sbc_front #(
    parameter int  COORD_WIDTH   = sbc_pkg::COORD_WIDTH_DEF,
    parameter int  FRACTION_BITS = sbc_pkg::FRACTION_BITS_DEF,
    parameter type t_job         = logic
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sbc_in_if.sink    in_ch,
    sbc_cfg_if.sink   cfg_ch,
    output logic      o_push,
    output t_job      o_job,
    input  logic      i_full
);
    localparam int CW  = COORD_WIDTH;
    localparam int MW  = (CW > sbc_pkg::THR_W) ? CW : sbc_pkg::THR_W;

    logic                  r_valid, r_mode;
    logic signed [CW-1:0]  r_lo [3];
    logic signed [CW-1:0]  r_hi [3];
    logic signed [CW-1:0]  r_vin [3];
    logic [sbc_pkg::THR_W-1:0] r_thr;
    // mover kept as center+half and center-half, plus velocity
    logic signed [CW:0]    r_p [3];
    logic signed [CW:0]    r_m [3];
    logic signed [CW-1:0]  r_vel [3];

    logic signed [CW:0]    n_p [3];
    logic signed [CW:0]    n_m [3];
    logic [2:0]            miss_a;
    logic                  consume, accept;

    assign consume      = r_valid && (!r_mode || !i_full);
    assign o_push       = r_valid && r_mode && !i_full;
    assign in_ch.ready  = !r_valid || consume;
    assign accept       = in_ch.valid && in_ch.ready;
    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode   <= in_ch.mode;
            r_lo[0]  <= in_ch.box_low_x;
            r_lo[1]  <= in_ch.box_low_y;
            r_lo[2]  <= in_ch.box_low_z;
            r_hi[0]  <= in_ch.box_high_x;
            r_hi[1]  <= in_ch.box_high_y;
            r_hi[2]  <= in_ch.box_high_z;
            r_vin[0] <= in_ch.velocity_x;
            r_vin[1] <= in_ch.velocity_y;
            r_vin[2] <= in_ch.velocity_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_thr   <= sbc_pkg::THR_RESET;
            for (int a = 0; a < 3; a++) begin
                r_p[a]   <= '0;
                r_m[a]   <= '0;
                r_vel[a] <= '0;
            end
        end else begin
            if (accept) begin
                r_valid <= 1'b1;
            end else if (consume) begin
                r_valid <= 1'b0;
            end
            if (cfg_ch.valid) begin
                r_thr <= cfg_ch.data;
            end
            if (consume && !r_mode) begin
                for (int a = 0; a < 3; a++) begin
                    r_p[a]   <= n_p[a];
                    r_m[a]   <= n_m[a];
                    r_vel[a] <= r_vin[a];
                end
            end
        end
    end

    for (genvar a = 0; a < 3; a++) begin : g_axis
        logic signed [CW:0]   sum, dif, ctr, half;
        logic signed [CW+1:0] d_min, d_max, d_en, d_ex;
        logic [CW-1:0]        uv;
        logic                 still, vpos;

        always_comb begin
            sum   = CW'(0) + ({r_lo[a][CW-1], r_lo[a]} + {r_hi[a][CW-1], r_hi[a]});
            dif   = {r_hi[a][CW-1], r_hi[a]} - {r_lo[a][CW-1], r_lo[a]};
            ctr   = sum >>> 1;
            half  = dif >>> 1;
            n_p[a] = ctr + half;
            n_m[a] = ctr - half;

            // distance from center to the grown slab faces
            d_min = {{2{r_lo[a][CW-1]}}, r_lo[a]} - {r_p[a][CW], r_p[a]};
            d_max = {{2{r_hi[a][CW-1]}}, r_hi[a]} - {r_m[a][CW], r_m[a]};
            uv    = r_vel[a][CW-1] ? (~r_vel[a] + 1'b1) : r_vel[a];
            still = (uv == '0) || (MW'(uv) < MW'(r_thr));
            vpos  = !r_vel[a][CW-1] && (r_vel[a] != '0);
            d_en  = vpos ? d_min : d_max;
            d_ex  = vpos ? d_max : d_min;
            miss_a[a] = still && (d_min > 0 || d_max < 0);

            o_job.still[a]     = still;
            o_job.vpos[a]      = vpos;
            o_job.uv[a]        = uv;
            o_job.neg[2*a]     = d_en[CW+1] != r_vel[a][CW-1];
            o_job.neg[2*a+1]   = d_ex[CW+1] != r_vel[a][CW-1];
            o_job.ud[2*a]      = d_en[CW+1] ? (~d_en + 1'b1) : d_en;
            o_job.ud[2*a+1]    = d_ex[CW+1] ? (~d_ex + 1'b1) : d_ex;
        end
    end

    assign o_job.miss = |miss_a;
endmodule

>>> rtl/core/sbc_div.sv
// Pipelined restoring divider lane: (ud << FRACTION_BITS) / uv, one
// quotient bit per stage, with a saturation flag. Depends on sbc_pkg.
module sbc_div #(
    parameter int COORD_WIDTH   = sbc_pkg::COORD_WIDTH_DEF,
    parameter int FRACTION_BITS = sbc_pkg::FRACTION_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [COORD_WIDTH+1:0]   i_ud,
    input  logic [COORD_WIDTH-1:0]   i_uv,
    input  logic                     i_neg,
    output logic [COORD_WIDTH-2:0]   o_q,
    output logic                     o_sat,
    output logic                     o_neg
);
    localparam int CW = COORD_WIDTH;
    localparam int QW = CW - 1;
    localparam int DW = CW + FRACTION_BITS + 2;
    localparam int XW = DW + CW;

    logic [DW-1:0]  r_rem [QW+1];
    logic [QW-1:0]  r_q   [QW+1];
    logic [CW-1:0]  r_uv  [QW+1];
    logic           r_neg [QW+1];
    logic           r_sat [QW+1];
    logic [DW-1:0]  num;

    assign num = {i_ud, {FRACTION_BITS{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= num;
            r_q[0]   <= '0;
            r_uv[0]  <= i_uv;
            r_neg[0] <= i_neg;
            // quotient would not fit in QW bits
            r_sat[0] <= XW'(num) >= (XW'(i_uv) << QW);
        end
    end

    for (genvar k = 1; k <= QW; k++) begin : g_stage
        localparam int B = QW - k;
        logic [XW-1:0] trial;
        logic          ge;
        logic [QW-1:0] n_q;

        always_comb begin
            trial  = XW'(r_uv[k-1]) << B;
            ge     = XW'(r_rem[k-1]) >= trial;
            n_q    = r_q[k-1];
            n_q[B] = ge;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= ge ? (r_rem[k-1] - trial[DW-1:0]) : r_rem[k-1];
                r_q[k]   <= n_q;
                r_uv[k]  <= r_uv[k-1];
                r_neg[k] <= r_neg[k-1];
                r_sat[k] <= r_sat[k-1];
            end
        end
    end

    assign o_q   = r_q[QW];
    assign o_sat = r_sat[QW];
    assign o_neg = r_neg[QW];
endmodule

>>> rtl/core/sbc_back.sv
// Back end: six divider lanes, slab interval merge and the result
// register. Depends on sbc_pkg, sbc_if and sbc_div.
module sbc_back #(
    parameter int  COORD_WIDTH   = sbc_pkg::COORD_WIDTH_DEF,
    parameter int  FRACTION_BITS = sbc_pkg::FRACTION_BITS_DEF,
    parameter type t_job         = logic
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_job       i_job,
    output logic       o_pop,
    sbc_out_if.source  out_ch
);
    localparam int CW = COORD_WIDTH;
    localparam int QW = CW - 1;
    localparam int TW = sbc_pkg::TIME_W;
    localparam int WW = (CW + 1 > TW) ? CW + 1 : TW;
    localparam logic signed [CW:0] NEG_INF = {1'b1, {CW{1'b0}}};
    localparam logic signed [CW:0] POS_INF = {1'b0, {CW{1'b1}}};
    localparam logic signed [CW:0] ONE_T   = (CW + 1)'(1) << FRACTION_BITS;
    localparam logic [WW-1:0]      ONE_W   = WW'(1) << FRACTION_BITS;

    typedef struct packed {
        logic       miss;
        logic [2:0] still;
        logic [2:0] vpos;
    } t_side;

    logic                 en;
    logic                 r_sv [QW+1];
    t_side                r_sb [QW+1];
    logic [QW-1:0]        dq   [6];
    logic                 dsat [6];
    logic                 dneg [6];
    logic signed [CW:0]   tval [6];

    logic                 r_tv;
    t_side                r_ts;
    logic signed [CW:0]   r_ten [3];
    logic signed [CW:0]   r_tex [3];

    logic                 r_out_valid;
    logic                 r_hit;
    logic [TW-1:0]        r_entry, r_exit;
    logic [1:0]           r_axis;
    logic signed [1:0]    r_normal;

    assign en    = !r_out_valid || out_ch.ready;
    assign o_pop = en && i_valid;

    for (genvar l = 0; l < 6; l++) begin : g_lane
        logic [CW-1:0] mag;
        sbc_div #(
            .COORD_WIDTH   (COORD_WIDTH),
            .FRACTION_BITS (FRACTION_BITS)
        ) u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_ud  (i_job.ud[l]),
            .i_uv  (i_job.uv[l/2]),
            .i_neg (i_job.neg[l]),
            .o_q   (dq[l]),
            .o_sat (dsat[l]),
            .o_neg (dneg[l])
        );
        always_comb begin
            if (dsat[l]) begin
                mag = dneg[l] ? {1'b1, {QW{1'b0}}} : {1'b0, {QW{1'b1}}};
            end else begin
                mag = {1'b0, dq[l]};
            end
            tval[l] = dneg[l] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        end
    end

    // control sideband travels alongside the divider stages
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sb[0] <= '{miss: i_job.miss, still: i_job.still, vpos: i_job.vpos};
            for (int k = 1; k <= QW; k++) begin
                r_sb[k] <= r_sb[k-1];
            end
            r_ts <= r_sb[QW];
            for (int a = 0; a < 3; a++) begin
                r_ten[a] <= r_sb[QW].still[a] ? NEG_INF : tval[2*a];
                r_tex[a] <= r_sb[QW].still[a] ? POS_INF : tval[2*a+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= QW; k++) begin
                r_sv[k] <= 1'b0;
            end
            r_tv <= 1'b0;
        end else if (en) begin
            r_sv[0] <= o_pop;
            for (int k = 1; k <= QW; k++) begin
                r_sv[k] <= r_sv[k-1];
            end
            r_tv <= r_sv[QW];
        end
    end

    logic signed [CW:0] t_in, t_out, e_in, e_out;
    logic [1:0]         axis;
    logic               hit;
    logic [WW-1:0]      ein_w, eout_w;

    always_comb begin
        if (r_ten[0] >= r_ten[1] && r_ten[0] >= r_ten[2]) begin
            axis = sbc_pkg::AXIS_X;
            t_in = r_ten[0];
        end else if (r_ten[1] >= r_ten[2]) begin
            axis = sbc_pkg::AXIS_Y;
            t_in = r_ten[1];
        end else begin
            axis = sbc_pkg::AXIS_Z;
            t_in = r_ten[2];
        end
        t_out = r_tex[0];
        if (r_tex[1] < t_out) t_out = r_tex[1];
        if (r_tex[2] < t_out) t_out = r_tex[2];
        hit    = !r_ts.miss && !(t_in > t_out) && !(t_in > ONE_T) && !(t_out < 0);
        e_in   = (t_in < 0) ? '0 : t_in;
        e_out  = (t_out > ONE_T) ? ONE_T : t_out;
        ein_w  = WW'(e_in);
        eout_w = WW'(e_out);
    end

    always_ff @(posedge i_clk) begin
        if (en && r_tv) begin
            r_hit <= hit;
            if (hit) begin
                r_entry  <= ein_w[TW-1:0];
                r_exit   <= eout_w[TW-1:0];
                r_axis   <= axis;
                r_normal <= r_ts.vpos[axis] ? sbc_pkg::NORMAL_NEG : sbc_pkg::NORMAL_POS;
            end else begin
                r_entry  <= ONE_W[TW-1:0];
                r_exit   <= ONE_W[TW-1:0];
                r_axis   <= sbc_pkg::AXIS_NONE;
                r_normal <= sbc_pkg::NORMAL_NONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_tv;
        end
    end

    assign out_ch.valid       = r_out_valid;
    assign out_ch.hit         = r_hit;
    assign out_ch.entry_time  = r_entry;
    assign out_ch.exit_time   = r_exit;
    assign out_ch.hit_axis    = r_axis;
    assign out_ch.normal_sign = r_normal;
endmodule

>>> rtl/core/swept_box_collision_core.sv
// Top level of the swept box collision core: front end, job queue and
// back end. Depends on sbc_pkg, sbc_if, sbc_front, sbc_fifo, sbc_back.
//
// Swept box test, signed fixed point. A load item (mode 0) stores the
// mover and gives no result; each test item (mode 1) gives one result.
// The block takes one item per cycle while the job queue has room and
// delivers one result per cycle when the output side is ready. A test
// goes from acceptance to result valid through the front end register,
// the job queue, the divider input stage, one stage per quotient bit
// (COORD_WIDTH - 1) in the six divider lanes, a time select stage and the
// result register. A load takes effect on the test right behind it.
// The threshold register may only be written while the block is idle.
module swept_box_collision_core #(
    parameter int COORD_WIDTH   = sbc_pkg::COORD_WIDTH_DEF,
    parameter int FRACTION_BITS = sbc_pkg::FRACTION_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sbc_in_if.sink     in_ch,
    sbc_out_if.source  out_ch,
    sbc_cfg_if.sink    cfg_ch
);
    localparam int CW = COORD_WIDTH;

    typedef struct packed {
        logic                 miss;
        logic [2:0]           still;
        logic [2:0]           vpos;
        logic [5:0]           neg;
        logic [5:0][CW+1:0]   ud;
        logic [2:0][CW-1:0]   uv;
    } t_job;

    logic push, full, pop, q_valid;
    t_job job_in, job_out;

    sbc_front #(
        .COORD_WIDTH   (COORD_WIDTH),
        .FRACTION_BITS (FRACTION_BITS),
        .t_job         (t_job)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch),
        .cfg_ch  (cfg_ch),
        .o_push  (push),
        .o_job   (job_in),
        .i_full  (full)
    );

    sbc_fifo #(
        .t_item (t_job)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (job_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (job_out)
    );

    sbc_back #(
        .COORD_WIDTH   (COORD_WIDTH),
        .FRACTION_BITS (FRACTION_BITS),
        .t_job         (t_job)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_job   (job_out),
        .o_pop   (pop),
        .out_ch  (out_ch)
    );
endmodule

>>> rtl/core/sbc_checker.sv
// Port-level checks for the swept box collision core, bound to the top
// level. Depends on sbc_pkg and swept_box_collision_core.
module sbc_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_valid,
    input logic                       i_ready,
    input logic                       i_hit,
    input logic [sbc_pkg::TIME_W-1:0] i_entry,
    input logic [sbc_pkg::TIME_W-1:0] i_exit,
    input logic [1:0]                 i_axis,
    input logic signed [1:0]          i_normal
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_hit) && $stable(i_entry))
        else $error("result changed while stalled");

    a_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_hit |-> i_axis == sbc_pkg::AXIS_NONE &&
        i_normal == sbc_pkg::NORMAL_NONE)
        else $error("miss result with axis or normal set");

    a_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_hit |-> i_axis != sbc_pkg::AXIS_NONE &&
        i_normal != sbc_pkg::NORMAL_NONE && i_entry <= i_exit)
        else $error("hit result inconsistent");

    a_rst: assert property (@(posedge i_clk)
        i_rst_n && !$past(i_rst_n) |-> !i_valid)
        else $error("result valid right after reset");
endmodule

bind swept_box_collision_core sbc_checker u_sbc_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (out_ch.valid),
    .i_ready  (out_ch.ready),
    .i_hit    (out_ch.hit),
    .i_entry  (out_ch.entry_time),
    .i_exit   (out_ch.exit_time),
    .i_axis   (out_ch.hit_axis),
    .i_normal (out_ch.normal_sign)
);

>>> verif/tb_sbc_pkg.sv
// Testbench types for the swept box collision core: input item and result
// record. Depends on sbc_pkg.
`timescale 1ns / 1ps
package tb_sbc_pkg;

    typedef struct {
        logic               mode;
        logic signed [31:0] lo [3];
        logic signed [31:0] hi [3];
        logic signed [31:0] vel [3];
    } box_item_t;

    typedef struct packed {
        logic                       hit;
        logic [sbc_pkg::TIME_W-1:0] entry_time;
        logic [sbc_pkg::TIME_W-1:0] exit_time;
        logic [1:0]                 hit_axis;
        logic signed [1:0]          normal_sign;
    } sweep_res_t;
endpackage

>>> verif/tb_top.sv
// Testbench top for swept_box_collision_core: directed table then random
// loads and tests, checked against an in-bench slab predictor.
// Depends on sbc_pkg, sbc_if, tb_sbc_pkg and the core RTL.
`timescale 1ns / 1ps
module tb_top;

    localparam int LATENCY = 40;
    localparam longint SAT_POS = 64'sd2147483647;
    localparam longint SAT_NEG = -64'sd2147483648;
    localparam longint ONE_T = 64'sd65536;
    localparam longint T_POS_INF = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint T_NEG_INF = 64'sh8000_0000_0000_0000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always #5 i_clk = ~i_clk;

    sbc_in_if  in_ch ();
    sbc_out_if out_ch ();
    sbc_cfg_if cfg_ch ();

    swept_box_collision_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .in_ch(in_ch.sink), .out_ch(out_ch.source), .cfg_ch(cfg_ch.sink)
    );

    // predictor state
    logic [sbc_pkg::THR_W-1:0] zv_thr = sbc_pkg::THR_RESET;
    longint mv_center [3] = '{0, 0, 0};
    longint mv_half [3] = '{0, 0, 0};
    longint mv_vel [3] = '{0, 0, 0};

    tb_sbc_pkg::sweep_res_t pending_hits[$];
    int n_errors = 0;
    int n_results = 0;
    int n_tests = 0;
    int n_hits = 0;
    bit quiet_out = 1'b0;
    bit use_typed = 1'b0;
    tb_sbc_pkg::sweep_res_t typed_res;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch #%0d on %s: got %0d want %0d at %0t", n_results, what, got, want,
                 $realtime);
        n_errors++;
    endtask

    function automatic longint floor_half(input longint x);
        if (x >= 0) return x / 2;
        return -((-x + 1) / 2);
    endfunction

    function automatic longint slab_div(input longint d, input longint v);
        bit neg;
        longint unsigned ud, uv, lim, q, r, m;
        neg = (d < 0) != (v < 0);
        ud = d < 0 ? -d : d;
        uv = v < 0 ? -v : v;
        lim = neg ? 64'd2147483648 : 64'd2147483647;
        q = ud / uv;
        r = ud % uv;
        if (q > (lim >> 16)) m = lim;
        else begin
            m = (q << 16) | ((r << 16) / uv);
            if (m > lim) m = lim;
        end
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic tb_sbc_pkg::sweep_res_t miss_res();
        tb_sbc_pkg::sweep_res_t r;
        r.hit = 1'b0;
        r.entry_time = 17'd65536;
        r.exit_time = 17'd65536;
        r.hit_axis = sbc_pkg::AXIS_NONE;
        r.normal_sign = sbc_pkg::NORMAL_NONE;
        return r;
    endfunction

    // returns 1 when the item yields a result
    function automatic bit sweep_predict(input tb_sbc_pkg::box_item_t it,
                                         output tb_sbc_pkg::sweep_res_t r);
        longint en [3], ex [3];
        longint emin, emax, c, v, tin, tout;
        longint unsigned uv;
        int ax;
        r = miss_res();
        if (it.mode == 1'b0) begin
            for (int a = 0; a < 3; a++) begin
                mv_center[a] = floor_half(longint'(it.lo[a]) + longint'(it.hi[a]));
                mv_half[a] = floor_half(longint'(it.hi[a]) - longint'(it.lo[a]));
                mv_vel[a] = longint'(it.vel[a]);
            end
            return 1'b0;
        end
        for (int a = 0; a < 3; a++) begin
            emin = longint'(it.lo[a]) - mv_half[a];
            emax = longint'(it.hi[a]) + mv_half[a];
            c = mv_center[a];
            v = mv_vel[a];
            uv = v < 0 ? -v : v;
            if (uv == 0 || uv < zv_thr) begin
                if (c < emin || c > emax) return 1'b1;
                en[a] = T_NEG_INF;
                ex[a] = T_POS_INF;
            end else if (v > 0) begin
                en[a] = slab_div(emin - c, v);
                ex[a] = slab_div(emax - c, v);
            end else begin
                en[a] = slab_div(emax - c, v);
                ex[a] = slab_div(emin - c, v);
            end
        end
        tin = en[0];
        if (en[1] > tin) tin = en[1];
        if (en[2] > tin) tin = en[2];
        tout = ex[0];
        if (ex[1] < tout) tout = ex[1];
        if (ex[2] < tout) tout = ex[2];
        if (tin > tout || tin > ONE_T || tout < 0) return 1'b1;
        if (en[0] >= en[1] && en[0] >= en[2]) ax = 0;
        else if (en[1] >= en[2]) ax = 1;
        else ax = 2;
        r.hit = 1'b1;
        r.entry_time = tin < 0 ? 17'd0 : 17'(tin);
        r.exit_time = tout > ONE_T ? 17'd65536 : 17'(tout);
        r.hit_axis = 2'(ax);
        r.normal_sign = mv_vel[ax] > 0 ? sbc_pkg::NORMAL_NEG : sbc_pkg::NORMAL_POS;
        return 1'b1;
    endfunction

    // result side: random ready bursts, compare against oldest expectation
    int rdy_burst = 0;
    always @(posedge i_clk) begin
        if (out_ch.valid && out_ch.ready && i_rst_n) begin
            n_results++;
            if (pending_hits.size() == 0) begin
                $display("unexpected result at %0t", $realtime);
                n_errors++;
            end else begin
                tb_sbc_pkg::sweep_res_t e;
                e = pending_hits.pop_front();
                if (e.hit) n_hits++;
                if (out_ch.hit !== e.hit) report_mismatch("hit", out_ch.hit, e.hit);
                if (out_ch.entry_time !== e.entry_time)
                    report_mismatch("entry_time", out_ch.entry_time, e.entry_time);
                if (out_ch.exit_time !== e.exit_time)
                    report_mismatch("exit_time", out_ch.exit_time, e.exit_time);
                if (out_ch.hit_axis !== e.hit_axis)
                    report_mismatch("hit_axis", out_ch.hit_axis, e.hit_axis);
                if (out_ch.normal_sign !== e.normal_sign)
                    report_mismatch("normal_sign", out_ch.normal_sign, e.normal_sign);
            end
        end
        if (quiet_out) out_ch.ready <= 1'b1;
        else if (rdy_burst > 0) begin
            rdy_burst--;
            out_ch.ready <= 1'b0;
        end else if ($urandom_range(0, 9) == 0) begin
            rdy_burst = $urandom_range(0, 15);
            out_ch.ready <= 1'b0;
        end else out_ch.ready <= 1'b1;
    end

    // valid stays up after a transfer; the next item or an idle gap replaces it
    task automatic send_item(input tb_sbc_pkg::box_item_t it, input bit gaps);
        tb_sbc_pkg::sweep_res_t r;
        int gap;
        if (gaps && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 16);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.mode <= it.mode;
        in_ch.box_low_x <= it.lo[0];
        in_ch.box_low_y <= it.lo[1];
        in_ch.box_low_z <= it.lo[2];
        in_ch.box_high_x <= it.hi[0];
        in_ch.box_high_y <= it.hi[1];
        in_ch.box_high_z <= it.hi[2];
        in_ch.velocity_x <= it.vel[0];
        in_ch.velocity_y <= it.vel[1];
        in_ch.velocity_z <= it.vel[2];
        do @(posedge i_clk); while (!in_ch.ready);
        if (sweep_predict(it, r)) begin
            n_tests++;
            if (use_typed) begin
                if (r !== typed_res) begin
                    $display("table row disagrees with predictor");
                    n_errors++;
                end
                r = typed_res;
            end
            pending_hits.push_back(r);
        end
    endtask

    task automatic drain_all();
        in_ch.valid <= 1'b0;
        while (pending_hits.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    task automatic write_threshold(input logic [sbc_pkg::THR_W-1:0] v);
        drain_all();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= v;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        zv_thr = v;
    endtask

    // random coordinate: mostly moderate, sometimes extreme
    function automatic logic signed [31:0] rnd_coord();
        case ($urandom_range(0, 9))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return $urandom;
            3: return $signed($urandom_range(0, 15)) - 8;
            default: return $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
        endcase
    endfunction

    function automatic tb_sbc_pkg::box_item_t rnd_item(input logic m);
        tb_sbc_pkg::box_item_t it;
        logic signed [31:0] c, h;
        it.mode = m;
        for (int a = 0; a < 3; a++) begin
            if ($urandom_range(0, 9) == 0) begin
                it.lo[a] = rnd_coord();
                it.hi[a] = rnd_coord();
            end else begin
                c = $signed($urandom_range(0, 32'h0007_FFFF)) - 32'sh0004_0000;
                h = $urandom_range(0, 32'h0002_0000);
                it.lo[a] = c - h;
                it.hi[a] = c + h;
            end
            it.vel[a] = $urandom_range(0, 5) == 0 ? rnd_coord()
                      : $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
        end
        return it;
    endfunction

    function automatic tb_sbc_pkg::box_item_t mk(input logic m, input int l, input int h,
                                                 input int v);
        tb_sbc_pkg::box_item_t it;
        it.mode = m;
        for (int a = 0; a < 3; a++) begin
            it.lo[a] = l;
            it.hi[a] = h;
            it.vel[a] = v;
        end
        return it;
    endfunction

    tb_sbc_pkg::box_item_t  dir_items[$];
    bit                     dir_typed[$];
    tb_sbc_pkg::sweep_res_t dir_res[$];

    task automatic add_row(input tb_sbc_pkg::box_item_t it, input bit typed,
                           input tb_sbc_pkg::sweep_res_t r);
        dir_items.push_back(it);
        dir_typed.push_back(typed);
        dir_res.push_back(r);
    endtask

    initial begin
        #20ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        tb_sbc_pkg::box_item_t it;
        tb_sbc_pkg::sweep_res_t hit0;
        logic [sbc_pkg::THR_W-1:0] thr_set [4] = '{16'd0, 16'hFFFF, 16'd7, 16'd300};
        in_ch.valid = 1'b0;
        in_ch.mode = 1'b0;
        in_ch.box_low_x = '0; in_ch.box_low_y = '0; in_ch.box_low_z = '0;
        in_ch.box_high_x = '0; in_ch.box_high_y = '0; in_ch.box_high_z = '0;
        in_ch.velocity_x = '0; in_ch.velocity_y = '0; in_ch.velocity_z = '0;
        out_ch.ready = 1'b1;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        hit0 = miss_res();
        hit0.hit = 1'b1;
        hit0.entry_time = 17'd0;
        hit0.normal_sign = sbc_pkg::NORMAL_POS;
        hit0.hit_axis = sbc_pkg::AXIS_X;
        // test before any load: still mover at origin, obstacle around it
        add_row(mk(1, -100, 100, 0), 1, hit0);
        add_row(mk(1, 10, 100, 0), 1, miss_res());  // early miss, not moving
        add_row(mk(1, -32'sh8000_0000, 32'sh7FFF_FFFF, 0), 1, hit0);
        add_row(mk(0, -65536, 65536, 32'sh0008_0000), 0, hit0);
        add_row(mk(1, 32'sh0002_0000, 32'sh0003_0000, 0), 0, hit0);
        add_row(mk(1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0), 0, hit0);
        add_row(mk(1, -32'sh8000_0000, -32'sh8000_0000, 0), 0, hit0);
        add_row(mk(0, 0, 0, -32'sh8000_0000), 0, hit0);
        add_row(mk(1, -32'sh8000_0000, 32'sh7FFF_FFFF, 0), 0, hit0);
        add_row(mk(1, -1000, -10, 0), 0, hit0);
        add_row(mk(0, 0, 0, 32'sh7FFF_FFFF), 0, hit0);
        add_row(mk(1, 32'sh7FFF_0000, 32'sh7FFF_FFFF, 0), 0, hit0);
        add_row(mk(0, 100, -100, 5), 0, hit0);      // inverted, slow velocity
        add_row(mk(1, -50, 50, 0), 0, hit0);
        add_row(mk(1, 300, 400, 0), 0, hit0);
        // tie: same entry on all axes, x wins; then y ahead of z
        it = mk(0, -10, 10, 32'sh0001_0000);
        add_row(it, 0, hit0);
        add_row(mk(1, 100, 200, 0), 0, hit0);
        it = mk(1, 100, 200, 0);
        it.lo[0] = 50;
        add_row(it, 0, hit0);
        it.vel = '{32'sh0001_0000, -32'sh0001_0000, 7};
        it.mode = 0;
        add_row(it, 0, hit0);
        add_row(mk(1, -200, 200, 0), 0, hit0);

        for (int i = 0; i < dir_items.size(); i++) begin
            use_typed = dir_typed[i];
            typed_res = dir_res[i];
            send_item(dir_items[i], 1'b1);
        end
        use_typed = 1'b0;

        for (int phase = 0; phase < 4; phase++) begin
            write_threshold(thr_set[phase]);
            for (int n = 0; n < 380; n++) begin
                quiet_out = (phase == 3 && n > 300);
                if ($urandom_range(0, 7) == 0) it = rnd_item(1'b0);
                else it = rnd_item(1'b1);
                if ($urandom_range(0, 30) == 0) it.mode = $urandom_range(0, 1);
                send_item(it, !(phase == 3 && n > 300));
                if (phase == 1 && n == 150) drain_all();
            end
        end

        drain_all();
        $display("covered %0d results (%0d hits) over four threshold settings",
                 n_results, n_hits);
        if (n_errors == 0 && pending_hits.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
